@@ design/dad_pkg.sv @@
// Shared widths, register indexes, reset constants and stage control type for the anchor decoder.
`timescale 1ns / 1ps
`default_nettype none

package dad_pkg;

    localparam int SCORE_W   = 16;
    localparam int COORD_W   = 16;
    localparam int OFFSET_W  = 12;
    localparam int SCALE_W   = 16;
    localparam int CLASS_W   = 7;
    localparam int ANCHOR_W  = 14;
    localparam int EDGE_W    = 24;
    localparam int CORNER_W  = 19;
    localparam int CPROD_W   = 36;
    localparam int EPROD_W   = 32;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 136;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CLASS_W-1:0] CLASS_LAST = '1;

    localparam logic signed [SCORE_W-1:0] RUN_MAX_RESET  = -16'sd28160;
    localparam logic [SCALE_W-1:0]        INV_SCALE_RESET = 16'd4096;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE = 2'd3;

    localparam logic signed [CPROD_W-1:0] CORNER_HALF = 36'sd4096;
    localparam logic signed [CPROD_W-1:0] CORNER_MAX  = 36'sd8388607;
    localparam logic signed [CPROD_W-1:0] CORNER_MIN  = -36'sd8388608;
    localparam logic [EPROD_W:0]          EXTENT_HALF = 33'd2048;

    typedef struct packed {
        logic load_prod;
        logic load_out;
    } stage_en_t;

endpackage

`default_nettype wire

@@ design/detection_anchor_decode_core.sv @@
// Top level: per-anchor class maximum, threshold test and box decode with stream ports.
//
//  channel   direction  handshake                 payload
//  s_        in         s_tvalid / s_tready       s_tdata class score and box, s_tlast last class
//  m_        out        m_tvalid / m_tready       m_tdata one detection
//  cfg_      in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One input word per cycle while s_tready is high; the class maximum updates as it is accepted.
// After its last-class word a detection passes the capture, multiply and round registers in order.
// The multiply stage (four products of up to 19 x 17 bits) sets the cycle time.
// Sync reset clears counters, valid flags, threshold and offsets; presets running max and scale.
// A stall on m_ holds the pipeline; s_tready drops only when every stage is full.
`timescale 1ns / 1ps
`default_nettype none

module detection_anchor_decode_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // class_score[15:0], centre_x[31:16], centre_y[47:32], box_width[63:48], box_height[79:64]
    input  wire logic [dad_pkg::IN_DATA_W-1:0]      s_tdata,
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // anchor_number[13:0], class_label[20:14], best_logit[36:21], left_edge[60:37],
    // top_edge[84:61], out_width[108:85], out_height[132:109], zero[135:133]
    output logic [dad_pkg::OUT_DATA_W-1:0]          m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [dad_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dad_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic signed [dad_pkg::SCORE_W-1:0] thresh_reg;
    logic [dad_pkg::OFFSET_W-1:0]       offset_x_reg, offset_y_reg;
    logic [dad_pkg::SCALE_W-1:0]        inv_scale_reg;

    logic signed [dad_pkg::SCORE_W-1:0] run_max_reg, run_max_next;
    logic [dad_pkg::CLASS_W-1:0]        run_class_reg, run_class_next;
    logic [dad_pkg::CLASS_W-1:0]        class_cnt_reg, class_cnt_next;
    logic [dad_pkg::ANCHOR_W-1:0]       anchor_cnt_reg, anchor_cnt_next;

    logic                               s_accept, cfg_accept;
    logic signed [dad_pkg::SCORE_W-1:0] score, cur_max;
    logic [dad_pkg::CLASS_W-1:0]        cur_class;
    logic                               pass;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    dad_pkg::stage_en_t stage_en;

    logic [dad_pkg::ANCHOR_W-1:0]       anchor1_reg, anchor2_reg, anchor3_reg;
    logic [dad_pkg::CLASS_W-1:0]        class1_reg, class2_reg, class3_reg;
    logic signed [dad_pkg::SCORE_W-1:0] logit1_reg, logit2_reg, logit3_reg;
    logic [dad_pkg::COORD_W-1:0]        cx1_reg, cy1_reg, w1_reg, h1_reg;

    logic signed [dad_pkg::EDGE_W-1:0]  left_edge, top_edge;
    logic [dad_pkg::EDGE_W-1:0]         out_width, out_height;

    assign s_accept   = s_tvalid & s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid & cfg_ready;

    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    assign stage_en.load_prod = rdy2;
    assign stage_en.load_out  = rdy3;

    always_comb begin
        score     = $signed(s_tdata[15:0]);
        cur_max   = run_max_reg;
        cur_class = run_class_reg;
        if (score > run_max_reg) begin
            cur_max   = score;
            cur_class = class_cnt_reg;
        end
        pass = cur_max > thresh_reg;

        run_max_next    = run_max_reg;
        run_class_next  = run_class_reg;
        class_cnt_next  = class_cnt_reg;
        anchor_cnt_next = anchor_cnt_reg;
        if (s_accept) begin
            if (s_tlast) begin
                run_max_next    = dad_pkg::RUN_MAX_RESET;
                run_class_next  = '0;
                class_cnt_next  = '0;
                anchor_cnt_next = anchor_cnt_reg + 1'b1;
            end else begin
                run_max_next   = cur_max;
                run_class_next = cur_class;
                if (class_cnt_reg != dad_pkg::CLASS_LAST) begin
                    class_cnt_next = class_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg     <= '0;
            offset_x_reg   <= '0;
            offset_y_reg   <= '0;
            inv_scale_reg  <= dad_pkg::INV_SCALE_RESET;
            run_max_reg    <= dad_pkg::RUN_MAX_RESET;
            run_class_reg  <= '0;
            class_cnt_reg  <= '0;
            anchor_cnt_reg <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
        end else begin
            if (cfg_accept) begin
                case (cfg_index)
                    dad_pkg::REG_THRESHOLD: thresh_reg    <= $signed(cfg_data);
                    dad_pkg::REG_OFFSET_X:  offset_x_reg  <= cfg_data[dad_pkg::OFFSET_W-1:0];
                    dad_pkg::REG_OFFSET_Y:  offset_y_reg  <= cfg_data[dad_pkg::OFFSET_W-1:0];
                    dad_pkg::REG_INV_SCALE: inv_scale_reg <= cfg_data;
                    default: ;
                endcase
            end
            run_max_reg    <= run_max_next;
            run_class_reg  <= run_class_next;
            class_cnt_reg  <= class_cnt_next;
            anchor_cnt_reg <= anchor_cnt_next;
            if (rdy1) begin
                v1_reg <= s_accept && s_tlast && pass;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            anchor1_reg <= anchor_cnt_reg;
            class1_reg  <= cur_class;
            logit1_reg  <= cur_max;
            cx1_reg     <= s_tdata[31:16];
            cy1_reg     <= s_tdata[47:32];
            w1_reg      <= s_tdata[63:48];
            h1_reg      <= s_tdata[79:64];
        end
        if (rdy2) begin
            anchor2_reg <= anchor1_reg;
            class2_reg  <= class1_reg;
            logit2_reg  <= logit1_reg;
        end
        if (rdy3) begin
            anchor3_reg <= anchor2_reg;
            class3_reg  <= class2_reg;
            logit3_reg  <= logit2_reg;
        end
    end

    dad_box_scale u_box_scale (
        .aclk          (aclk),
        .stage_en      (stage_en),
        .offset_x      (offset_x_reg),
        .offset_y      (offset_y_reg),
        .inverse_scale (inv_scale_reg),
        .centre_x      (cx1_reg),
        .centre_y      (cy1_reg),
        .box_width     (w1_reg),
        .box_height    (h1_reg),
        .left_edge     (left_edge),
        .top_edge      (top_edge),
        .out_width     (out_width),
        .out_height    (out_height)
    );

    assign m_tvalid = v3_reg;
    assign m_tdata  = {3'b000, out_height, out_width, top_edge, left_edge,
                       logit3_reg, class3_reg, anchor3_reg};

endmodule

`default_nettype wire

@@ design/dad_box_scale.sv @@
// Box decode datapath: corner form, letterbox offset removal, scaling, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none

module dad_box_scale (
    input  wire logic                                 aclk,
    input  wire dad_pkg::stage_en_t                   stage_en,
    input  wire logic [dad_pkg::OFFSET_W-1:0]         offset_x,
    input  wire logic [dad_pkg::OFFSET_W-1:0]         offset_y,
    input  wire logic [dad_pkg::SCALE_W-1:0]          inverse_scale,
    input  wire logic [dad_pkg::COORD_W-1:0]          centre_x,
    input  wire logic [dad_pkg::COORD_W-1:0]          centre_y,
    input  wire logic [dad_pkg::COORD_W-1:0]          box_width,
    input  wire logic [dad_pkg::COORD_W-1:0]          box_height,
    output logic signed [dad_pkg::EDGE_W-1:0]         left_edge,
    output logic signed [dad_pkg::EDGE_W-1:0]         top_edge,
    output logic [dad_pkg::EDGE_W-1:0]                out_width,
    output logic [dad_pkg::EDGE_W-1:0]                out_height
);

    logic signed [dad_pkg::CORNER_W-1:0] corner_x, corner_y;
    logic signed [dad_pkg::SCALE_W:0]    scale_s;

    logic signed [dad_pkg::CPROD_W-1:0] prod_x_reg, prod_y_reg, prod_x_next, prod_y_next;
    logic [dad_pkg::EPROD_W-1:0]        prod_w_reg, prod_h_reg, prod_w_next, prod_h_next;

    logic signed [dad_pkg::CPROD_W-1:0] rnd_x, rnd_y;
    logic [dad_pkg::EPROD_W:0]          rnd_w, rnd_h;

    logic signed [dad_pkg::EDGE_W-1:0]  left_reg, left_next, top_reg, top_next;
    logic [dad_pkg::EDGE_W-1:0]         width_reg, width_next, height_reg, height_next;

    function automatic logic signed [dad_pkg::EDGE_W-1:0] sat_corner(
        input logic signed [dad_pkg::CPROD_W-1:0] v
    );
        logic signed [dad_pkg::EDGE_W-1:0] r;
        if (v > dad_pkg::CORNER_MAX) begin
            r = dad_pkg::EDGE_W'(dad_pkg::CORNER_MAX);
        end else if (v < dad_pkg::CORNER_MIN) begin
            r = dad_pkg::EDGE_W'(dad_pkg::CORNER_MIN);
        end else begin
            r = v[dad_pkg::EDGE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [dad_pkg::EDGE_W-1:0] sat_extent(
        input logic [dad_pkg::EPROD_W:0] v
    );
        logic [dad_pkg::EDGE_W-1:0] r;
        if (|v[dad_pkg::EPROD_W:dad_pkg::EDGE_W]) begin
            r = '1;
        end else begin
            r = v[dad_pkg::EDGE_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        scale_s  = $signed({1'b0, inverse_scale});
        corner_x = $signed({2'b00, centre_x, 1'b0}) - $signed({3'b000, box_width})
                 - $signed({2'b00, offset_x, 5'b00000});
        corner_y = $signed({2'b00, centre_y, 1'b0}) - $signed({3'b000, box_height})
                 - $signed({2'b00, offset_y, 5'b00000});

        prod_x_next = dad_pkg::CPROD_W'(corner_x) * dad_pkg::CPROD_W'(scale_s);
        prod_y_next = dad_pkg::CPROD_W'(corner_y) * dad_pkg::CPROD_W'(scale_s);
        prod_w_next = dad_pkg::EPROD_W'(box_width) * dad_pkg::EPROD_W'(inverse_scale);
        prod_h_next = dad_pkg::EPROD_W'(box_height) * dad_pkg::EPROD_W'(inverse_scale);

        rnd_x = (prod_x_reg + dad_pkg::CORNER_HALF) >>> 13;
        rnd_y = (prod_y_reg + dad_pkg::CORNER_HALF) >>> 13;
        rnd_w = ({1'b0, prod_w_reg} + dad_pkg::EXTENT_HALF) >> 12;
        rnd_h = ({1'b0, prod_h_reg} + dad_pkg::EXTENT_HALF) >> 12;

        left_next   = sat_corner(rnd_x);
        top_next    = sat_corner(rnd_y);
        width_next  = sat_extent(rnd_w);
        height_next = sat_extent(rnd_h);
    end

    always_ff @(posedge aclk) begin
        if (stage_en.load_prod) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_w_reg <= prod_w_next;
            prod_h_reg <= prod_h_next;
        end
        if (stage_en.load_out) begin
            left_reg   <= left_next;
            top_reg    <= top_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign left_edge  = left_reg;
    assign top_edge   = top_reg;
    assign out_width  = width_reg;
    assign out_height = height_reg;

endmodule

`default_nettype wire

@@ tb/anchor_decode_checker.sv @@
// Checker for the anchor decoder: tracks class maxima and registers, predicts detections, compares.
`timescale 1ns / 1ps

module anchor_decode_checker
    import dad_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_tlast,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         outstanding
);

    typedef struct packed {
        logic [2:0]                 pad;
        logic [EDGE_W-1:0]          height;
        logic [EDGE_W-1:0]          width;
        logic signed [EDGE_W-1:0]   top_edge;
        logic signed [EDGE_W-1:0]   left_edge;
        logic signed [SCORE_W-1:0]  logit;
        logic [CLASS_W-1:0]         label;
        logic [ANCHOR_W-1:0]        anchor;
    } detection_t;

    detection_t detections_due[$];
    int         error_total = 0;

    logic signed [SCORE_W-1:0]  threshold;
    logic [OFFSET_W-1:0]        pad_x;
    logic [OFFSET_W-1:0]        pad_y;
    logic [SCALE_W-1:0]         inv_scale;

    logic signed [SCORE_W-1:0]  best_score;
    logic [CLASS_W-1:0]         best_class;
    logic [CLASS_W-1:0]         class_num;
    logic [ANCHOR_W-1:0]        anchor_num;

    function automatic logic [EDGE_W-1:0] corner_edge(logic [COORD_W-1:0] centre,
                                                      logic [COORD_W-1:0] size,
                                                      logic [OFFSET_W-1:0] pad,
                                                      logic [SCALE_W-1:0] inv);
        longint span;
        longint scaled;
        span   = 2 * longint'(centre) - longint'(size) - 32 * longint'(pad);
        scaled = (span * longint'(inv) + 64'sd4096) >>> 13;
        if (scaled > 64'sd8388607) scaled = 64'sd8388607;
        if (scaled < -64'sd8388608) scaled = -64'sd8388608;
        return scaled[EDGE_W-1:0];
    endfunction

    function automatic logic [EDGE_W-1:0] scaled_extent(logic [COORD_W-1:0] size,
                                                        logic [SCALE_W-1:0] inv);
        longint scaled;
        scaled = (longint'(size) * longint'(inv) + 64'sd2048) >>> 12;
        if (scaled > 64'sd16777215) scaled = 64'sd16777215;
        return scaled[EDGE_W-1:0];
    endfunction

    task automatic reset_anchor();
        best_score = RUN_MAX_RESET;
        best_class = '0;
        class_num  = '0;
    endtask

    // advance the class maximum by one word; queue a detection on a passing last class
    task automatic absorb_score(logic [IN_DATA_W-1:0] word, logic last);
        logic signed [SCORE_W-1:0] score;
        detection_t                hit;
        score = word[15:0];
        if (score > best_score) begin
            best_score = score;
            best_class = class_num;
        end
        if (class_num != CLASS_LAST) class_num = class_num + 1'b1;
        if (last) begin
            if (best_score > threshold) begin
                hit.pad       = '0;
                hit.anchor    = anchor_num;
                hit.label     = best_class;
                hit.logit     = best_score;
                hit.left_edge = corner_edge(word[31:16], word[63:48], pad_x, inv_scale);
                hit.top_edge  = corner_edge(word[47:32], word[79:64], pad_y, inv_scale);
                hit.width     = scaled_extent(word[63:48], inv_scale);
                hit.height    = scaled_extent(word[79:64], inv_scale);
                detections_due.insert(detections_due.size(), hit);
            end
            reset_anchor();
            anchor_num = anchor_num + 1'b1;
        end
    endtask

    task automatic compare_field(string field, logic [EDGE_W-1:0] want, logic [EDGE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
            error_total++;
        end
    endtask

    always @(posedge aclk) begin
        detection_t want;
        detection_t got;
        if (!aresetn) begin
            threshold  = '0;
            pad_x      = '0;
            pad_y      = '0;
            inv_scale  = INV_SCALE_RESET;
            anchor_num = '0;
            reset_anchor();
            detections_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_THRESHOLD: threshold = cfg_data;
                    REG_OFFSET_X:  pad_x     = cfg_data[OFFSET_W-1:0];
                    REG_OFFSET_Y:  pad_y     = cfg_data[OFFSET_W-1:0];
                    REG_INV_SCALE: inv_scale = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (detections_due.size() == 0) begin
                    $display("%0t: detection expected none actual 0x%0h", $time, m_tdata);
                    error_total++;
                end else begin
                    want = detections_due.pop_front();
                    compare_field("anchor_number", want.anchor, got.anchor);
                    compare_field("class_label", want.label, got.label);
                    compare_field("best_logit", want.logit, got.logit);
                    compare_field("left_edge", want.left_edge, got.left_edge);
                    compare_field("top_edge", want.top_edge, got.top_edge);
                    compare_field("out_width", want.width, got.width);
                    compare_field("out_height", want.height, got.height);
                    compare_field("pad", want.pad, got.pad);
                end
            end
            if (s_tvalid && s_tready) absorb_score(s_tdata, s_tlast);
        end
        outstanding <= detections_due.size();
        mismatches  <= error_total;
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the anchor decoder: clock, reset, register setup, score stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;
    import dad_pkg::*;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int outstanding;

    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_arm  = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    int          words_sent   = 0;
    logic [15:0] cur_threshold = '0;

    detection_anchor_decode_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    anchor_decode_checker decode_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // hold off the result side for a long stretch on request, else stall at random
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_arm != hold_seen) begin
            hold_seen <= hold_arm;
            hold_left <= 300;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_class(logic [15:0] score, logic last, logic [15:0] cx, logic [15:0] cy,
                              logic [15:0] bw, logic [15:0] bh);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bh, bw, cy, cx, score};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // drain every pending detection, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_regs(logic [15:0] thr, logic [11:0] ox, logic [11:0] oy, logic [15:0] inv);
        settle();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_OFFSET_X, {4'($urandom), ox});
        write_reg(REG_OFFSET_Y, {4'($urandom), oy});
        write_reg(REG_INV_SCALE, inv);
        cfg_valid <= 1'b0;
        cur_threshold = thr;
    endtask

    task automatic randomize_regs();
        logic [11:0] ox;
        logic [11:0] oy;
        logic [15:0] inv;
        ox = ($urandom_range(3) == 0) ? 12'hFFF : 12'($urandom_range(300));
        oy = ($urandom_range(3) == 0) ? 12'h000 : 12'($urandom);
        case ($urandom_range(3))
            0: inv = INV_SCALE_RESET;
            1: inv = 16'hFFFF;
            2: inv = 16'($urandom_range(1, 600));
            default: inv = 16'($urandom);
        endcase
        set_regs(16'($urandom_range(4000)) - 16'd2000, ox, oy, inv);
    endtask

    function automatic logic [15:0] pick_score(logic [15:0] prev);
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return RUN_MAX_RESET;
                    3: return RUN_MAX_RESET - 16'sd1;
                    default: return RUN_MAX_RESET + 16'sd1;
                endcase
            end
            1: return cur_threshold + 16'($urandom_range(8)) - 16'd4;
            2: return prev;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_anchor(int classes);
        logic [15:0] score;
        score = 16'($urandom);
        for (int i = 0; i < classes; i++) begin
            score = pick_score(score);
            send_class(score, i == classes - 1, pick_coord(), pick_coord(), pick_coord(),
                       pick_coord());
        end
    endtask

    task automatic run_anchors(int words);
        int stop_at;
        int pick;
        stop_at = words_sent + words;
        while (words_sent < stop_at) begin
            pick = $urandom_range(199);
            if (pick == 0) send_anchor(126 + $urandom_range(5));
            else if (pick < 30) send_anchor(1);
            else send_anchor(2 + $urandom_range(6));
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset registers: threshold 0, no offset, unit scale
        send_class(16'h7FFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_class(16'd5, 1'b0, 16'd100, 16'd200, 16'd10, 16'd20);
        send_class(16'd9, 1'b0, 16'd300, 16'd400, 16'd30, 16'd40);
        send_class(16'd9, 1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_class(16'd0, 1'b1, 16'd1234, 16'd4321, 16'd55, 16'd66);
        send_class(16'd1, 1'b1, 16'd1234, 16'd4321, 16'd55, 16'd66);
        send_class(16'h8000, 1'b0, 16'd7, 16'd8, 16'd9, 16'd10);
        send_class(RUN_MAX_RESET, 1'b1, 16'd7, 16'd8, 16'd9, 16'd10);

        // threshold below the floor: an anchor with nothing above it still passes
        set_regs(16'h8000, 12'hFFF, 12'hFFF, 16'hFFFF);
        send_class(16'h8000, 1'b0, 16'd1, 16'd2, 16'd3, 16'd4);
        send_class(RUN_MAX_RESET, 1'b0, 16'd1, 16'd2, 16'd3, 16'd4);
        send_class(16'h8000, 1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        send_class(RUN_MAX_RESET + 16'sd1, 1'b1, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);

        set_regs(16'h7FFF, 12'h000, 12'h000, 16'h0000);
        send_class(16'h7FFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // zero scale: every coordinate collapses to 0
        set_regs(-16'sd100, 12'd100, 12'd200, 16'h0000);
        send_class(16'd1, 1'b0, 16'd5000, 16'd6000, 16'd700, 16'd800);
        send_class(16'd3, 1'b0, 16'd5000, 16'd6000, 16'd700, 16'd800);
        send_class(16'd2, 1'b1, 16'd5000, 16'd6000, 16'd700, 16'd800);

        // no idling; one anchor past the class limit, then a long result hold-off
        randomize_regs();
        idle_pct  = 0;
        stall_pct = 0;
        for (int i = 0; i < 130; i++) begin
            send_class((i == 129) ? 16'h7FFF : 16'($urandom_range(2000)) - 16'd1000, i == 129,
                       pick_coord(), pick_coord(), pick_coord(), pick_coord());
        end
        set_regs(16'h8000, 12'd16, 12'd8, INV_SCALE_RESET);
        hold_arm <= ~hold_arm;
        run_anchors(120);

        randomize_regs();
        idle_pct  = 63;
        stall_pct = 0;
        run_anchors(260);

        randomize_regs();
        idle_pct  = 0;
        stall_pct = 63;
        run_anchors(260);

        randomize_regs();
        idle_pct  = 7;
        stall_pct = 7;
        run_anchors(260);

        settle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
